// ===== design/gon_pkg.sv =====
package gon_pkg;

    typedef logic signed [13:0] sexp_t;

    typedef enum logic [1:0] {
        FOP_MUL,
        FOP_DIV,
        FOP_SQRT
    } fop_t;

    typedef struct packed {
        logic start;
        fop_t op;
    } fpu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fpu_stat_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NORM,
        F_MUL,
        F_DIV,
        F_SQRT,
        F_DENORM,
        F_ROUND,
        F_DONE
    } fpu_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOP,
        ST_SQ,
        ST_MP,
        ST_TP,
        ST_B1,
        ST_B2,
        ST_B3,
        ST_DV,
        ST_S1,
        ST_S2,
        ST_OUT
    } seq_state_t;

    localparam logic [63:0] DBL_INF  = 64'h7FF0000000000000;
    localparam logic [63:0] DBL_ONE  = 64'h3FF0000000000000;
    localparam logic [63:0] PI3_BITS = 64'h403F019B59389D7C;
    localparam logic [10:0] EXP_MAX  = 11'h7FF;
    localparam int          MAX_POWER = 5;

    // ((2l-1)!!)^2 as a double
    function automatic logic [63:0] dfact_sq_bits(input logic [2:0] l);
        logic [63:0] v;
        case (l)
            3'd2:    v = 64'h4022000000000000;
            3'd3:    v = 64'h406C200000000000;
            3'd4:    v = 64'h40C5888000000000;
            3'd5:    v = 64'h412B40C200000000;
            default: v = DBL_ONE;
        endcase
        return v;
    endfunction

endpackage

// ===== design/gon_fpu.sv =====
module gon_fpu (
    input  logic               aclk,
    input  logic               aresetn,
    input  gon_pkg::fpu_req_t  req,
    input  logic [63:0]        op_a,
    input  logic [63:0]        op_b,
    output gon_pkg::fpu_stat_t stat,
    output logic [63:0]        result
);
    import gon_pkg::*;

    fpu_state_t  state_reg, state_next;
    fop_t        op_reg, op_next;
    logic [53:0] ma_reg, ma_next;
    logic [52:0] mb_reg, mb_next;
    sexp_t       ea_reg, ea_next, eb_reg, eb_next;
    logic [52:0] hi_reg, hi_next, lo_reg, lo_next;
    logic [56:0] rem_reg, rem_next;
    logic [55:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [55:0] sig_reg, sig_next;
    logic        stk_reg, stk_next;
    sexp_t       bexp_reg, bexp_next;
    logic [63:0] res_reg, res_next;

    function automatic logic [52:0] unpack_mant(input logic [63:0] x);
        return (x[62:52] == 11'd0) ? {1'b0, x[51:0]} : {1'b1, x[51:0]};
    endfunction

    function automatic sexp_t unpack_exp(input logic [63:0] x);
        return (x[62:52] == 11'd0) ? -14'sd1074 : ($signed({3'b000, x[62:52]}) - 14'sd1075);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg   <= op_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        sig_reg  <= sig_next;
        stk_reg  <= stk_next;
        bexp_reg <= bexp_next;
        res_reg  <= res_next;
    end

    always_comb begin
        logic        a_zero, a_inf, b_zero, b_inf, ge, inc;
        logic [53:0] sum;
        logic [52:0] hi_n, lo_n;
        logic [54:0] rn;
        logic [55:0] q_n;
        logic [56:0] r2, trial, r_n;
        logic [53:0] mant;
        sexp_t       se;
        sexp_t       bm1;

        state_next = state_reg;
        op_next    = op_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        sig_next   = sig_reg;
        stk_next   = stk_reg;
        bexp_next  = bexp_reg;
        res_next   = res_reg;

        a_zero = (op_a[62:0] == 63'd0);
        a_inf  = (op_a[62:52] == EXP_MAX);
        b_zero = (op_b[62:0] == 63'd0);
        b_inf  = (op_b[62:52] == EXP_MAX);
        sum    = {1'b0, hi_reg} + (mb_reg[0] ? {1'b0, ma_reg[52:0]} : 54'd0);
        hi_n   = sum[53:1];
        lo_n   = {sum[0], lo_reg[52:1]};
        ge     = 1'b0;
        rn     = '0;
        q_n    = '0;
        r2     = '0;
        trial  = '0;
        r_n    = '0;
        mant   = '0;
        se     = '0;
        inc    = 1'b0;
        bm1    = bexp_reg - 14'sd1;

        unique case (state_reg)
            F_IDLE: begin
                if (req.start) begin
                    op_next = req.op;
                    ma_next = {1'b0, unpack_mant(op_a)};
                    ea_next = unpack_exp(op_a);
                    mb_next = (req.op == FOP_SQRT) ? {1'b1, 52'd0} : unpack_mant(op_b);
                    eb_next = unpack_exp(op_b);
                    if (a_zero || (req.op == FOP_MUL && b_zero)) begin
                        res_next   = 64'd0;
                        state_next = F_DONE;
                    end else if (a_inf || (req.op == FOP_MUL && b_inf)) begin
                        res_next   = DBL_INF;
                        state_next = F_DONE;
                    end else begin
                        state_next = F_NORM;
                    end
                end
            end
            F_NORM: begin
                // subnormals: one bit of leading-zero shift per cycle
                if (!ma_reg[52]) begin
                    ma_next = ma_reg << 1;
                    ea_next = ea_reg - 14'sd1;
                end else if (!mb_reg[52]) begin
                    mb_next = mb_reg << 1;
                    eb_next = eb_reg - 14'sd1;
                end else begin
                    cnt_next = '0;
                    case (op_reg)
                        FOP_MUL: begin
                            hi_next    = '0;
                            lo_next    = '0;
                            state_next = F_MUL;
                        end
                        FOP_DIV: begin
                            rem_next   = {4'd0, ma_reg[52:0]};
                            quo_next   = '0;
                            state_next = F_DIV;
                        end
                        default: begin
                            if (ea_reg[0]) begin
                                ma_next = ma_reg << 1;
                                ea_next = ea_reg - 14'sd1;
                            end
                            rem_next   = '0;
                            quo_next   = '0;
                            state_next = F_SQRT;
                        end
                    endcase
                end
            end
            F_MUL: begin
                hi_next  = hi_n;
                lo_next  = lo_n;
                mb_next  = mb_reg >> 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd52) begin
                    se = ea_reg + eb_reg;
                    if (hi_n[52]) begin
                        sig_next  = {hi_n, lo_n[52:50]};
                        stk_next  = |lo_n[49:0];
                        bexp_next = se + 14'sd1128;
                    end else begin
                        sig_next  = {hi_n[51:0], lo_n[52:49]};
                        stk_next  = |lo_n[48:0];
                        bexp_next = se + 14'sd1127;
                    end
                    state_next = F_DENORM;
                end
            end
            F_DIV: begin
                ge       = rem_reg[54:0] >= {2'b00, mb_reg};
                rn       = ge ? (rem_reg[54:0] - {2'b00, mb_reg}) : rem_reg[54:0];
                rem_next = {1'b0, rn, 1'b0};
                q_n      = {quo_reg[54:0], ge};
                quo_next = q_n;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd55) begin
                    se       = ea_reg - eb_reg;
                    stk_next = (rn != 55'd0);
                    if (q_n[55]) begin
                        sig_next  = q_n;
                        bexp_next = se + 14'sd1023;
                    end else begin
                        sig_next  = q_n << 1;
                        bexp_next = se + 14'sd1022;
                    end
                    state_next = F_DENORM;
                end
            end
            F_SQRT: begin
                r2       = {rem_reg[54:0], ma_reg[53:52]};
                trial    = {1'b0, quo_reg[53:0], 2'b01};
                ge       = r2 >= trial;
                r_n      = ge ? (r2 - trial) : r2;
                q_n      = {2'b00, quo_reg[52:0], ge};
                rem_next = r_n;
                quo_next = q_n;
                ma_next  = ma_reg << 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd53) begin
                    inc  = q_n[0] && ((r_n != 57'd0) || q_n[1]);
                    mant = {1'b0, q_n[53:1]} + {53'd0, inc};
                    se   = (ea_reg >>> 1) + 14'sd1049;
                    if (mant[53]) begin
                        se = se + 14'sd1;
                    end
                    res_next   = {1'b0, se[10:0], mant[51:0]};
                    state_next = F_DONE;
                end
            end
            F_DENORM: begin
                // right shift into the subnormal range, gathering sticky
                if (bexp_reg >= 14'sd1) begin
                    state_next = F_ROUND;
                end else if (bexp_reg < -14'sd60) begin
                    sig_next  = '0;
                    stk_next  = 1'b1;
                    bexp_next = 14'sd1;
                end else begin
                    sig_next  = sig_reg >> 1;
                    stk_next  = stk_reg | sig_reg[0];
                    bexp_next = bexp_reg + 14'sd1;
                end
            end
            F_ROUND: begin
                if (bexp_reg >= 14'sd2047) begin
                    res_next = DBL_INF;
                end else begin
                    inc      = sig_reg[2] && (sig_reg[3] || sig_reg[1] || sig_reg[0] || stk_reg);
                    // a carry out of the mantissa moves into the exponent field
                    res_next = {1'b0, bm1[10:0], 52'd0} + {11'd0, sig_reg[55:3]}
                               + {63'd0, inc};
                end
                state_next = F_DONE;
            end
            F_DONE: begin
                state_next = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign stat.busy = (state_reg != F_IDLE);
    assign stat.done = (state_reg == F_DONE);
    assign result    = res_reg;

endmodule

// ===== design/gaussian_orbital_norm_core.sv =====
// channel  direction  payload                               handshake
// s_       in         exponent_bits[63:0], lx, ly, lz       s_valid / s_ready
// m_       out        norm_bits[63:0], error                m_valid / m_ready
//
// one item at a time; a rejected item goes from idle straight to the output state
// a valid item runs 9 to 12 operations on one shared double unit: multiplies, a divide and
// two square roots, plus shift steps for subnormal operands and denormal results;
// a zero or infinite operand a, or b of a multiply, skips the iteration and goes straight to done
// reset clears the sequencer, the unit and the result valid
// once the next result is ready, a stalled result holds the sequencer until it is taken
module gaussian_orbital_norm_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_exponent_bits,
    input  logic [2:0]  s_lx,
    input  logic [2:0]  s_ly,
    input  logic [2:0]  s_lz,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_norm_bits,
    output logic        m_error
);
    import gon_pkg::*;

    seq_state_t  state_reg, state_next;
    logic        wait_reg, wait_next;
    logic [2:0]  a_reg, a_next;
    logic [2:0]  s_reg, s_next;
    logic [2:0]  lx_reg, lx_next, ly_reg, ly_next, lz_reg, lz_next;
    logic [63:0] p_reg, p_next, base_reg, base_next, d_reg, d_next;
    logic [63:0] res_reg, res_next;
    logic        err_reg, err_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_norm_reg, m_norm_next;
    logic        m_err_reg, m_err_next;

    fpu_req_t    fpu_req;
    fpu_stat_t   fpu_stat;
    logic [63:0] fpu_a, fpu_b, fpu_res;

    gon_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .op_a    (fpu_a),
        .op_b    (fpu_b),
        .stat    (fpu_stat),
        .result  (fpu_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wait_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            m_valid_reg <= m_valid_next;
        end
        a_reg      <= a_next;
        s_reg      <= s_next;
        lx_reg     <= lx_next;
        ly_reg     <= ly_next;
        lz_reg     <= lz_next;
        p_reg      <= p_next;
        base_reg   <= base_next;
        d_reg      <= d_next;
        res_reg    <= res_next;
        err_reg    <= err_next;
        m_norm_reg <= m_norm_next;
        m_err_reg  <= m_err_next;
    end

    always_comb begin
        logic [4:0]  sum;
        logic        bad;
        logic        is_op;
        logic [10:0] t_exp;

        state_next   = state_reg;
        wait_next    = wait_reg;
        a_next       = a_reg;
        s_next       = s_reg;
        lx_next      = lx_reg;
        ly_next      = ly_reg;
        lz_next      = lz_reg;
        p_next       = p_reg;
        base_next    = base_reg;
        d_next       = d_reg;
        res_next     = res_reg;
        err_next     = err_reg;
        m_norm_next  = m_norm_reg;
        m_err_next   = m_err_reg;
        m_valid_next = m_valid_reg && !m_ready;

        sum   = {2'b00, s_lx} + {2'b00, s_ly} + {2'b00, s_lz};
        bad   = (sum > 5'(MAX_POWER)) || s_exponent_bits[63] || (s_exponent_bits == 64'd0)
                || (s_exponent_bits[62:52] == EXP_MAX);
        t_exp = 11'd1026 + {6'd0, s_reg, 2'b00};

        fpu_req.op = FOP_MUL;
        fpu_a      = p_reg;
        fpu_b      = base_reg;
        is_op      = 1'b0;

        unique case (state_reg)
            ST_SQ: begin
                is_op = 1'b1;
                fpu_a = base_reg;
            end
            ST_MP: is_op = 1'b1;
            ST_TP: begin
                is_op = 1'b1;
                fpu_a = {1'b0, t_exp, 52'd0};
                fpu_b = p_reg;
            end
            ST_B1: begin
                is_op = 1'b1;
                fpu_a = dfact_sq_bits(lx_reg);
                fpu_b = dfact_sq_bits(ly_reg);
            end
            ST_B2: begin
                is_op = 1'b1;
                fpu_a = d_reg;
                fpu_b = dfact_sq_bits(lz_reg);
            end
            ST_B3: begin
                is_op = 1'b1;
                fpu_a = d_reg;
                fpu_b = PI3_BITS;
            end
            ST_DV: begin
                is_op      = 1'b1;
                fpu_req.op = FOP_DIV;
                fpu_b      = d_reg;
            end
            ST_S1, ST_S2: begin
                is_op      = 1'b1;
                fpu_req.op = FOP_SQRT;
            end
            default: is_op = 1'b0;
        endcase
        fpu_req.start = is_op && !wait_reg;
        if (fpu_req.start) begin
            wait_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    lx_next   = s_lx;
                    ly_next   = s_ly;
                    lz_next   = s_lz;
                    s_next    = sum[2:0];
                    a_next    = sum[2:0] + 3'd1;
                    p_next    = s_exponent_bits;
                    base_next = s_exponent_bits;
                    if (bad) begin
                        res_next   = 64'd0;
                        err_next   = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        err_next   = 1'b0;
                        // e^(2s+3) = e * (e^2)^(s+1)
                        a_next     = sum[2:0] + 3'd1;
                        state_next = ST_LOOP;
                    end
                end
            end
            ST_LOOP: begin
                state_next = (a_reg == 3'd0) ? ST_TP : ST_SQ;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_norm_next  = res_reg;
                    m_err_next   = err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                if (fpu_stat.done && wait_reg) begin
                    wait_next = 1'b0;
                    case (state_reg)
                        ST_SQ: begin
                            base_next = fpu_res;
                            if (a_reg[0]) begin
                                state_next = ST_MP;
                            end else begin
                                a_next     = a_reg >> 1;
                                state_next = ST_LOOP;
                            end
                        end
                        ST_MP: begin
                            p_next     = fpu_res;
                            a_next     = a_reg >> 1;
                            state_next = ST_LOOP;
                        end
                        ST_TP: begin
                            p_next     = fpu_res;
                            state_next = ST_B1;
                        end
                        ST_B1: begin
                            d_next     = fpu_res;
                            state_next = ST_B2;
                        end
                        ST_B2: begin
                            d_next     = fpu_res;
                            state_next = ST_B3;
                        end
                        ST_B3: begin
                            d_next     = fpu_res;
                            state_next = ST_DV;
                        end
                        ST_DV: begin
                            p_next     = fpu_res;
                            state_next = ST_S1;
                        end
                        ST_S1: begin
                            p_next     = fpu_res;
                            state_next = ST_S2;
                        end
                        default: begin
                            res_next   = fpu_res;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
        endcase
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_norm_bits = m_norm_reg;
    assign m_error     = m_err_reg;

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_err_reg |-> m_norm_reg == 64'd0)
        else $error("error beat carries nonzero norm");

    a_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        fpu_stat.done |-> wait_reg)
        else $error("unit finished without a pending request");

    a_idle_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !fpu_stat.busy)
        else $error("unit busy while sequencer idle");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while item in flight");
`endif

endmodule

// ===== sim/gaussian_orbital_norm_core_tb.sv =====
module gaussian_orbital_norm_core_tb;
    import gon_pkg::*;

    typedef struct {
        logic [63:0] norm;
        logic        err;
    } norm_res_t;

    typedef struct {
        logic [63:0] ebits;
        logic [2:0]  lx, ly, lz;
        bit          typed;
        logic [63:0] norm;
        logic        err;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_exponent_bits = '0;
    logic [2:0]  s_lx = '0, s_ly = '0, s_lz = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_norm_bits;
    logic        m_error;

    norm_res_t   norm_q[$];
    int          fail_cnt = 0;
    int          hold_req = 0;
    dir_row_t    dir_tbl[$];

    gaussian_orbital_norm_core dut (.*);

    always #10 aclk = ~aclk;

    // correctly rounded square root of a non-negative double, on bits
    function automatic logic [63:0] sqrt_rn(input logic [63:0] x);
        logic [63:0] m, q, r, mant, pair, trial;
        logic [10:0] be;
        int          e, j, bexp;
        be = x[62:52];
        q = 0;
        r = 0;
        if (x[62:0] == 0) return 64'd0;
        if (be == EXP_MAX) return DBL_INF;
        if (be == 0) begin
            m = {12'd0, x[51:0]};
            e = -1074;
            while (m < 64'h0010000000000000) begin
                m = m << 1;
                e--;
            end
        end else begin
            m = {12'd1, x[51:0]};
            e = int'(be) - 1075;
        end
        if (e % 2 != 0) begin
            m = m << 1;
            e--;
        end
        for (int k = 53; k >= 0; k--) begin
            j = 2 * k;
            pair = (j >= 54) ? ((m >> (j - 54)) & 64'd3) : 64'd0;
            r = (r << 2) | pair;
            trial = (q << 2) | 64'd1;
            if (r >= trial) begin
                r = r - trial;
                q = (q << 1) | 64'd1;
            end else begin
                q = q << 1;
            end
        end
        mant = q >> 1;
        if (q[0] && (r != 0 || mant[0])) mant++;
        bexp = e / 2 - 26 + 52 + 1023;
        if (mant == 64'h0020000000000000) begin
            mant = mant >> 1;
            bexp++;
        end
        return {bexp[11:0], mant[51:0]};
    endfunction

    function automatic real dfact_sq(input logic [2:0] l);
        case (l)
            3'd2:    return 9.0;
            3'd3:    return 225.0;
            3'd4:    return 11025.0;
            3'd5:    return 893025.0;
            default: return 1.0;
        endcase
    endfunction

    function automatic norm_res_t orbital_norm(input logic [63:0] ebits,
                                               input logic [2:0] lx, ly, lz);
        norm_res_t res;
        int        s, a;
        real       p, base, t, b, q;
        s = lx + ly + lz;
        if (s > MAX_POWER || ebits[63] || ebits == 0 || ebits[62:52] == EXP_MAX) begin
            res.norm = 64'd0;
            res.err = 1'b1;
            return res;
        end
        a = 2 * s + 3;
        p = 1.0;
        base = $bitstoreal(ebits);
        t = $bitstoreal(64'(1023 + 4 * s + 3) << 52);
        b = dfact_sq(lx) * dfact_sq(ly) * dfact_sq(lz);
        while (a != 0) begin
            if (a & 1) p = p * base;
            a = a >> 1;
            if (a != 0) base = base * base;
        end
        q = (t * p) / (b * $bitstoreal(PI3_BITS));
        res.norm = sqrt_rn(sqrt_rn($realtobits(q)));
        res.err = 1'b0;
        return res;
    endfunction

    function automatic logic [63:0] rand_exponent();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0, 1:    v = {$urandom, $urandom};
            2:       v = {12'd0, 20'($urandom), $urandom} >> $urandom_range(0, 51);
            3: begin
                case ($urandom_range(0, 4))
                    0:       v = 64'd0;
                    1:       v = 64'h8000000000000000;
                    2:       v = DBL_INF;
                    3:       v = {1'b0, EXP_MAX, 20'($urandom), $urandom};
                    default: v = {1'b1, 11'($urandom), 20'($urandom), $urandom};
                endcase
            end
            default: v = {1'b0, 11'(1023 + $urandom_range(0, 80) - 40),
                          20'($urandom), $urandom};
        endcase
        return v;
    endfunction

    // one beat; entered and left at a falling edge
    task automatic send_beat(input logic [63:0] ebits, input logic [2:0] lx, ly, lz,
                             input bit typed, input logic [63:0] tnorm, input logic terr);
        norm_res_t res;
        s_valid <= 1'b1;
        s_exponent_bits <= ebits;
        s_lx <= lx;
        s_ly <= ly;
        s_lz <= lz;
        do @(posedge aclk); while (!(s_valid && s_ready));
        res = orbital_norm(ebits, lx, ly, lz);
        if (typed) begin
            res.norm = tnorm;
            res.err = terr;
        end
        norm_q.push_back(res);
        @(negedge aclk);
    endtask

    task automatic sender_gap();
        int n;
        case ($urandom_range(0, 19))
            0:       n = $urandom_range(50, 900);
            1, 2, 3: n = $urandom_range(1, 8);
            default: n = 0;
        endcase
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // receiver backpressure
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                stall = hold_req;
                hold_req = 0;
            end else if (stall == 0) begin
                case ($urandom_range(0, 199))
                    0:       stall = $urandom_range(100, 1500);
                    1, 2, 3: stall = $urandom_range(1, 10);
                    default: stall = 0;
                endcase
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (norm_q.size() == 0) begin
                $display("%0t: unexpected beat norm=%h error=%b", $time, m_norm_bits, m_error);
                fail_cnt++;
            end else begin
                if (m_norm_bits !== norm_q[0].norm) begin
                    $display("%0t: norm_bits expected %h actual %h", $time,
                             norm_q[0].norm, m_norm_bits);
                    fail_cnt++;
                end
                if (m_error !== norm_q[0].err) begin
                    $display("%0t: error expected %b actual %b", $time,
                             norm_q[0].err, m_error);
                    fail_cnt++;
                end
                void'(norm_q.pop_front());
            end
        end
    end

    initial begin
        #800000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [2:0] lx, ly, lz;
        dir_tbl = '{
            '{64'h3FF0000000000000, 3'd2, 3'd2, 3'd2, 1, 64'd0, 1'b1},
            '{64'h3FF0000000000000, 3'd7, 3'd7, 3'd7, 1, 64'd0, 1'b1},
            '{64'h3FF0000000000000, 3'd0, 3'd0, 3'd6, 1, 64'd0, 1'b1},
            '{64'h0000000000000000, 3'd0, 3'd0, 3'd0, 1, 64'd0, 1'b1},
            '{64'h8000000000000000, 3'd1, 3'd0, 3'd0, 1, 64'd0, 1'b1},
            '{64'hBFF0000000000000, 3'd0, 3'd0, 3'd0, 1, 64'd0, 1'b1},
            '{64'hFFFFFFFFFFFFFFFF, 3'd0, 3'd0, 3'd0, 1, 64'd0, 1'b1},
            '{64'h7FF0000000000000, 3'd0, 3'd0, 3'd0, 1, 64'd0, 1'b1},
            '{64'h7FF8000000000000, 3'd0, 3'd1, 3'd0, 1, 64'd0, 1'b1},
            '{64'h7FF0000000000001, 3'd0, 3'd0, 3'd1, 1, 64'd0, 1'b1},
            '{64'h3FF0000000000000, 3'd0, 3'd0, 3'd0, 1, 64'd0, 1'b0},
            '{64'h7FEFFFFFFFFFFFFF, 3'd5, 3'd0, 3'd0, 1, DBL_INF, 1'b0},
            '{64'h0000000000000001, 3'd0, 3'd0, 3'd0, 1, 64'd0, 1'b0},
            '{64'h000FFFFFFFFFFFFF, 3'd0, 3'd0, 3'd0, 0, 64'd0, 1'b0},
            '{64'h3FF0000000000000, 3'd5, 3'd0, 3'd0, 0, 64'd0, 1'b0},
            '{64'h3FF0000000000000, 3'd0, 3'd5, 3'd0, 0, 64'd0, 1'b0},
            '{64'h3FF0000000000000, 3'd0, 3'd0, 3'd5, 0, 64'd0, 1'b0},
            '{64'h3FE0000000000000, 3'd1, 3'd1, 3'd1, 0, 64'd0, 1'b0},
            '{64'h4024000000000000, 3'd2, 3'd0, 3'd0, 0, 64'd0, 1'b0},
            '{64'h3F50624DD2F1A9FC, 3'd0, 3'd3, 3'd2, 0, 64'd0, 1'b0},
            '{64'h54B249AD2594C37D, 3'd4, 3'd1, 3'd0, 0, 64'd0, 1'b0},
            '{64'h0010000000000000, 3'd0, 3'd1, 3'd4, 0, 64'd0, 1'b0}
        };
        // unit exponent, no power: (8/pi^3)^(1/4) is computed, not typed
        dir_tbl[10].typed = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (dir_tbl[i]) begin
            send_beat(dir_tbl[i].ebits, dir_tbl[i].lx, dir_tbl[i].ly, dir_tbl[i].lz,
                      dir_tbl[i].typed, dir_tbl[i].norm, dir_tbl[i].err);
            sender_gap();
        end
        for (int n = 0; n < 1800; n++) begin
            if (n == 500) hold_req = 3000;
            if (n == 900) begin
                s_valid <= 1'b0;
                wait (norm_q.size() == 0);
                @(negedge aclk);
            end
            if ($urandom_range(0, 9) == 0) begin
                lx = 3'($urandom);
                ly = 3'($urandom);
                lz = 3'($urandom);
            end else begin
                do begin
                    lx = 3'($urandom_range(0, 5));
                    ly = 3'($urandom_range(0, 5));
                    lz = 3'($urandom_range(0, 5));
                end while (lx + ly + lz > MAX_POWER);
            end
            send_beat(rand_exponent(), lx, ly, lz, 0, 64'd0, 1'b0);
            sender_gap();
        end
        s_valid <= 1'b0;
        wait (norm_q.size() == 0);
        repeat (50) @(posedge aclk);
        if (fail_cnt == 0 && norm_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
